FILE: hdl/lfu_pr_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed field widths for the LFU page replacement unit.
// No dependencies; used by lfu_page_replacement_unit.
package lfu_pr_pkg;

  localparam int PAGE_W   = 16;
  localparam int FIDX_W   = 4;
  localparam int TOTAL_W  = 32;
  localparam int CFG_W    = 5;
  localparam int IN_W     = 16;
  localparam int RES_W    = 1 + FIDX_W + 1 + PAGE_W + TOTAL_W + TOTAL_W;
  localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

  // Declared highest field first so that hit lands in bit 0.
  typedef struct packed {
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] fault_total;
    logic [PAGE_W-1:0]  evicted_page;
    logic               evicted_valid;
    logic [FIDX_W-1:0]  frame_index;
    logic               hit;
  } lfu_result_t;

endpackage

FILE: hdl/lfu_page_replacement_unit.sv
`timescale 1ns / 1ps
// LFU page replacement unit: frame table, sequential lookup/victim scan, totals.
// Depends on lfu_pr_pkg.
//
// Each input beat is one page reference. The unit walks the active frames one
// per cycle through a single read port of the frame table, and in the same
// pass looks for a resident copy of the page (lowest index wins) and for the
// frame with the smallest use count (lowest index wins on ties; empty frames
// count as zero). From acceptance to result an item goes through N reads,
// where N is the active frame count (frames_in_use clamped to 1..FRAMES),
// then the last compare landing, then the sequencer seeing the end of the
// compare stream, and then the write step that updates the table and loads
// the result register. s_tready rises again as the result loads, so a new
// reference is not accepted until the current one is finished. The frame
// table read is registered, so the scan is set by that one memory port.
// s_tready is high only while the unit is idle; a finished result sits in an
// output register and the next reference may be accepted while it waits to
// be taken. If the previous result is still unclaimed when a scan ends, the
// table update and result load hold until that beat is taken.
// frames_in_use may be written only while no reference is in flight;
// frames outside the active range keep their contents but are not looked
// at. Use counts saturate at 2^COUNT_BITS - 1 and the fault/hit totals at
// 2^32 - 1.
module lfu_page_replacement_unit #(
  parameter int FRAMES     = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration: frames_in_use
  input  logic                           cfg_we,
  input  logic [lfu_pr_pkg::CFG_W-1:0]   cfg_wdata,
  // Reference input
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lfu_pr_pkg::IN_W-1:0]    s_tdata,   // [15:0] page_number
  // Result output
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] hit, [4:1] frame_index, [5] evicted_valid, [21:6] evicted_page,
  // [53:22] fault_total, [85:54] hit_total, [87:86] zero
  output logic [lfu_pr_pkg::OUT_W-1:0]   m_tdata
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int UW     = $clog2(FRAMES + 1);
  localparam int CW     = (UW > lfu_pr_pkg::CFG_W) ? UW : lfu_pr_pkg::CFG_W;
  localparam int PW     = lfu_pr_pkg::PAGE_W;
  localparam int TW     = lfu_pr_pkg::TOTAL_W;
  localparam int WORD_W = PW + COUNT_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TW-1:0]         TOTAL_MAX = '1;

  // Configuration register
  logic [lfu_pr_pkg::CFG_W-1:0] frames_in_use;

  // Frame table: page and use count in memory, valid bits in flops
  logic [WORD_W-1:0] frame_mem [FRAMES];
  logic [FRAMES-1:0] frame_valid;
  logic [WORD_W-1:0] rd_word;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_word;

  // Sequencer
  logic [1:0]        state;
  logic [PW-1:0]     page;
  logic [UW-1:0]     used;
  logic [UW-1:0]     used_next;
  logic [UW-1:0]     iss;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;

  // Scan results
  logic                  found;
  logic [IDX_W-1:0]      hit_idx;
  logic [COUNT_BITS-1:0] hit_count;
  logic [COUNT_BITS-1:0] min_count;
  logic [IDX_W-1:0]      min_idx;
  logic                  min_valid;
  logic [PW-1:0]         min_page;

  // Totals and result register
  logic [TW-1:0]           fault_counter;
  logic [TW-1:0]           hit_counter;
  lfu_pr_pkg::lfu_result_t result;

  logic                  out_free;
  logic [PW-1:0]         rd_page;
  logic [COUNT_BITS-1:0] rd_count;
  logic [COUNT_BITS-1:0] eff_count;
  logic [CW-1:0]         cfg_ext;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign rd_page   = rd_word[WORD_W-1:COUNT_BITS];
  assign rd_count  = rd_word[COUNT_BITS-1:0];
  // An empty frame counts as zero whatever the memory holds
  assign eff_count = rd_valid ? rd_count : '0;
  assign rd_addr   = iss[IDX_W-1:0];

  // Clamp the configured frame count to 1..FRAMES
  always_comb begin
    cfg_ext = CW'(frames_in_use);
    if (cfg_ext == '0) begin
      used_next = UW'(1);
    end else if (cfg_ext > CW'(FRAMES)) begin
      used_next = UW'(FRAMES);
    end else begin
      used_next = UW'(cfg_ext);
    end
  end

  // Table update: hit bumps the count, fault loads the page with count one
  always_comb begin
    wr_en   = (state == ST_WRITE) && out_free;
    wr_addr = found ? hit_idx : min_idx;
    if (found) begin
      wr_word = {page, (hit_count == COUNT_MAX) ? hit_count : hit_count + 1'b1};
    end else begin
      wr_word = {page, COUNT_BITS'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    rd_word <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid    <= 1'b0;
      frame_valid <= '0;
    end else begin
      rd_valid <= frame_valid[rd_addr];
      if (wr_en) begin
        frame_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lfu_pr_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // Sequencer: accept, scan, write back and post the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cmp_vld       <= 1'b0;
      m_tvalid      <= 1'b0;
      fault_counter <= '0;
      hit_counter   <= '0;
    end else begin
      // Raise valid when a result loads, drop it once the beat is taken
      if (wr_en) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            page    <= s_tdata[PW-1:0];
            used    <= used_next;
            iss     <= '0;
            cmp_vld <= 1'b0;
            found   <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one read a cycle; compare the word that came back
          if (iss != used) begin
            iss     <= iss + 1'b1;
            cmp_vld <= 1'b1;
            cmp_idx <= rd_addr;
          end else begin
            cmp_vld <= 1'b0;
            if (!cmp_vld) begin
              state <= ST_WRITE;
            end
          end
          if (cmp_vld) begin
            if (!found && rd_valid && (rd_page == page)) begin
              found     <= 1'b1;
              hit_idx   <= cmp_idx;
              hit_count <= rd_count;
            end
            if ((cmp_idx == '0) || (eff_count < min_count)) begin
              min_count <= eff_count;
              min_idx   <= cmp_idx;
              min_valid <= rd_valid;
              min_page  <= rd_page;
            end
          end
        end
        ST_WRITE: begin
          // Hold until the result register is free
          if (out_free) begin
            result.hit         <= found;
            result.frame_index <= lfu_pr_pkg::FIDX_W'(found ? hit_idx : min_idx);
            if (found) begin
              result.evicted_valid <= 1'b0;
              result.evicted_page  <= '0;
              result.fault_total   <= fault_counter;
              if (hit_counter != TOTAL_MAX) begin
                hit_counter      <= hit_counter + 1'b1;
                result.hit_total <= hit_counter + 1'b1;
              end else begin
                result.hit_total <= hit_counter;
              end
            end else begin
              result.evicted_valid <= min_valid;
              result.evicted_page  <= min_valid ? min_page : '0;
              result.hit_total     <= hit_counter;
              if (fault_counter != TOTAL_MAX) begin
                fault_counter      <= fault_counter + 1'b1;
                result.fault_total <= fault_counter + 1'b1;
              end else begin
                result.fault_total <= fault_counter;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(lfu_pr_pkg::OUT_W - lfu_pr_pkg::RES_W){1'b0}}, result};

endmodule
